@@ rtl/chm_pkg.sv @@
// Shared types and constants for the two-table cuckoo hash insert block.
// Used by every module of the block; it depends on nothing else.
package chm_pkg;

  localparam int KEY_W          = 31;
  localparam int KICK_W         = 7;
  localparam int SIDX_W         = 10;
  localparam int STATUS_W       = 2;
  localparam int TABLE_SIZE_DEF = 11;

  localparam logic [KICK_W-1:0] KICKS_RESET = 7'd16;

  localparam logic [STATUS_W-1:0] STATUS_PLACED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_READ    = 2'd2;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic TSEL_SECOND = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_H1_GO,
    ST_H1_WAIT,
    ST_RD1,
    ST_CHK1,
    ST_H2A_GO,
    ST_H2A_WAIT,
    ST_H2B_GO,
    ST_H2B_WAIT,
    ST_RD2,
    ST_CHK2,
    ST_RD_WAIT,
    ST_RD_OUT
  } state_t;

  typedef enum logic [1:0] {
    HSRC_CUR,
    HSRC_EVICT,
    HSRC_QUOT
  } hash_src_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_EMPTY,
    RES_PLACED,
    RES_DROP_CUR,
    RES_DROP_EVICT,
    RES_READ
  } res_kind_t;

  typedef struct packed {
    logic      clr_wr;
    logic      load;
    logic      hash_go;
    hash_src_t hash_src;
    logic      take_slot;
    logic      take_quot;
    logic      wr1;
    logic      swap1;
    logic      wr2;
    logic      swap2;
    logic      kick;
    res_kind_t res;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic key_zero;
    logic hash_done;
    logic t1_empty;
    logic t2_empty;
    logic kick_limit;
  } stat_t;

endpackage

@@ rtl/cuckoo_hash_insert.sv @@
// Top level of the two-table cuckoo hash insert block.
// Depends on chm_pkg, chm_controller and chm_datapath.
//
// A request is taken when start is high and busy is low. Its single result
// appears on status, dropped_key, read_key and kick_count for one cycle with
// done high, the cycle after the request finishes, and is not held: the
// receiver must take it then. After reset a clearing pass empties both tables,
// with busy high. A slot read keeps busy high through ST_RD_WAIT and ST_RD_OUT,
// and an insert of zero does not raise busy. An insert passes ST_H1_GO,
// ST_H1_WAIT, ST_RD1 and ST_CHK1 for the first table; every displacement into
// the second table passes ST_H2A_GO to ST_CHK2, hashing twice, and every one back
// into the first table repeats ST_H1_GO to ST_CHK1. Slot numbers come from the
// four-stage constant divider, shared by both tables; table reads are registered.
module cuckoo_hash_insert
  import chm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  logic [KEY_W-1:0]    key,
  input  logic                table_select,
  input  logic [SIDX_W-1:0]   slot_index,
  input  logic                cfg_write_en,
  input  logic [KICK_W-1:0]   cfg_write_data,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    dropped_key,
  output logic [KEY_W-1:0]    read_key,
  output logic [KICK_W-1:0]   kick_count
);

  ctrl_t cmd;
  stat_t stat;

  chm_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  chm_datapath #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .key           (key),
    .table_select  (table_select),
    .slot_index    (slot_index),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .done          (done),
    .status        (status),
    .dropped_key   (dropped_key),
    .read_key      (read_key),
    .kick_count    (kick_count)
  );

endmodule

@@ rtl/chm_divmod.sv @@
// Four-stage pipelined divider by the constant table size, giving quotient and remainder.
// Uses a reciprocal multiply with one correction step; depends on chm_pkg.
module chm_divmod
  import chm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [KEY_W-1:0]              x,
  output logic                          valid,
  output logic [KEY_W-1:0]              quot,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int SHIFT = KEY_W + $clog2(TABLE_SIZE + 1) - 1;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / TABLE_SIZE;
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);

  logic [2:0]       v;
  logic [63:0]      p1;
  logic [KEY_W-1:0] x1, x2, x3;
  logic [KEY_W-1:0] qe2, qe3;
  logic [KEY_W-1:0] pq3;
  logic [KEY_W-1:0] r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else begin
      v     <= {v[1:0], go};
      valid <= v[2];
    end
  end

  assign r = x3 - pq3;

  always_ff @(posedge clk) begin
    p1  <= {33'd0, x} * {32'd0, RECIP};
    x1  <= x;
    qe2 <= KEY_W'(p1 >> SHIFT);
    x2  <= x1;
    pq3 <= qe2 * DIVISOR;
    qe3 <= qe2;
    x3  <= x2;
    if (r >= DIVISOR) begin
      rem  <= IDX_W'(r - DIVISOR);
      quot <= qe3 + KEY_W'(1);
    end else begin
      rem  <= IDX_W'(r);
      quot <= qe3;
    end
  end

endmodule

@@ rtl/chm_datapath.sv @@
// Datapath of the cuckoo hash block: both tables, key registers, kick counter and result registers.
// Depends on chm_pkg and chm_divmod; driven by chm_controller commands.
module chm_datapath
  import chm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               cmd,
  output stat_t               stat,
  input  logic [KEY_W-1:0]    key,
  input  logic                table_select,
  input  logic [SIDX_W-1:0]   slot_index,
  input  logic                cfg_write_en,
  input  logic [KICK_W-1:0]   cfg_write_data,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    dropped_key,
  output logic [KEY_W-1:0]    read_key,
  output logic [KICK_W-1:0]   kick_count
);

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic [KEY_W-1:0]  t1_mem [TABLE_SIZE];
  logic [KEY_W-1:0]  t2_mem [TABLE_SIZE];
  logic [KEY_W-1:0]  t1_q, t2_q;
  logic [KEY_W-1:0]  cur_key, evict_key, quot_key;
  logic [IDX_W-1:0]  slot, clr_addr;
  logic [KICK_W-1:0] kicks, max_kicks;
  logic              read_sel, read_oob;
  logic              slot_oob;

  logic [KEY_W-1:0]  hash_in, hash_quot;
  logic [IDX_W-1:0]  hash_rem;
  logic              hash_valid;

  logic [STATUS_W-1:0] status_next;
  logic [KEY_W-1:0]    dropped_next, read_next;
  logic [KICK_W-1:0]   kick_next;

  always_comb begin
    case (cmd.hash_src)
      HSRC_CUR:   hash_in = cur_key;
      HSRC_EVICT: hash_in = evict_key;
      HSRC_QUOT:  hash_in = quot_key;
      default:    hash_in = cur_key;
    endcase
  end

  chm_divmod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_divmod (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.hash_go),
    .x    (hash_in),
    .valid(hash_valid),
    .quot (hash_quot),
    .rem  (hash_rem)
  );

  assign slot_oob = 32'(slot_index) >= 32'(TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      t1_mem[clr_addr] <= '0;
      t2_mem[clr_addr] <= '0;
    end else begin
      if (cmd.wr1) begin
        t1_mem[slot] <= cur_key;
      end
      if (cmd.wr2) begin
        t2_mem[slot] <= evict_key;
      end
    end
    t1_q <= t1_mem[slot];
    t2_q <= t2_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      max_kicks <= KICKS_RESET;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (cfg_write_en) begin
        max_kicks <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_key  <= key;
      read_sel <= table_select;
      read_oob <= slot_oob;
      slot     <= slot_oob ? '0 : slot_index[IDX_W-1:0];
    end else begin
      if (cmd.take_slot) begin
        slot <= hash_rem;
      end
      if (cmd.swap2) begin
        cur_key <= t2_q;
      end
    end
    if (cmd.take_quot) begin
      quot_key <= hash_quot;
    end
    if (cmd.swap1) begin
      evict_key <= t1_q;
    end
    if (cmd.load) begin
      kicks <= '0;
    end else if (cmd.kick) begin
      kicks <= kicks + KICK_W'(1);
    end
  end

  assign stat.clr_last   = (clr_addr == IDX_W'(TABLE_SIZE - 1));
  assign stat.key_zero   = (key == '0);
  assign stat.hash_done  = hash_valid;
  assign stat.t1_empty   = (t1_q == '0);
  assign stat.t2_empty   = (t2_q == '0);
  assign stat.kick_limit = (kicks >= max_kicks);

  always_comb begin
    status_next  = STATUS_PLACED;
    dropped_next = '0;
    read_next    = '0;
    kick_next    = '0;
    case (cmd.res)
      RES_PLACED: begin
        kick_next = kicks;
      end
      RES_DROP_CUR: begin
        status_next  = STATUS_DROPPED;
        dropped_next = cur_key;
        kick_next    = kicks;
      end
      RES_DROP_EVICT: begin
        status_next  = STATUS_DROPPED;
        dropped_next = evict_key;
        kick_next    = kicks;
      end
      RES_READ: begin
        status_next = STATUS_READ;
        if (!read_oob) begin
          read_next = (read_sel == TSEL_SECOND) ? t2_q : t1_q;
        end
      end
      default: begin
        status_next = STATUS_PLACED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.res != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res != RES_NONE) begin
      status      <= status_next;
      dropped_key <= dropped_next;
      read_key    <= read_next;
      kick_count  <= kick_next;
    end
  end

  // A reported result is consistent with its status.
  a_placed_clean: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_PLACED |-> dropped_key == '0 && read_key == '0)
    else $error("placed result carries key data");

  a_read_no_kicks: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_READ |-> kick_count == '0 && dropped_key == '0)
    else $error("read result carries insert data");

  a_dropped_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_DROPPED |-> dropped_key != '0)
    else $error("dropped key is an empty slot value");

endmodule

@@ rtl/chm_controller.sv @@
// Controller state machine of the cuckoo hash block: clearing pass, insert chain and slot reads.
// Depends on chm_pkg; commands chm_datapath through ctrl_t and watches stat_t.
module chm_controller
  import chm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  command,
  input  stat_t stat,
  output ctrl_t cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_READ) begin
            state_next = ST_RD_WAIT;
          end else if (!stat.key_zero) begin
            state_next = ST_H1_GO;
          end
        end
      end
      ST_H1_GO:    state_next = ST_H1_WAIT;
      ST_H1_WAIT: begin
        if (stat.hash_done) state_next = ST_RD1;
      end
      ST_RD1:      state_next = ST_CHK1;
      ST_CHK1: begin
        if (stat.t1_empty || stat.kick_limit) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_H2A_GO;
        end
      end
      ST_H2A_GO:   state_next = ST_H2A_WAIT;
      ST_H2A_WAIT: begin
        if (stat.hash_done) state_next = ST_H2B_GO;
      end
      ST_H2B_GO:   state_next = ST_H2B_WAIT;
      ST_H2B_WAIT: begin
        if (stat.hash_done) state_next = ST_RD2;
      end
      ST_RD2:      state_next = ST_CHK2;
      ST_CHK2: begin
        if (stat.t2_empty || stat.kick_limit) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_H1_GO;
        end
      end
      ST_RD_WAIT:  state_next = ST_RD_OUT;
      ST_RD_OUT:   state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.hash_src = HSRC_CUR;
    cmd.res      = RES_NONE;
    busy         = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_READ || !stat.key_zero) begin
            cmd.load = 1'b1;
          end else begin
            cmd.res = RES_EMPTY;
          end
        end
      end
      ST_H1_GO: begin
        cmd.hash_go  = 1'b1;
        cmd.hash_src = HSRC_CUR;
      end
      ST_H1_WAIT: begin
        cmd.take_slot = stat.hash_done;
      end
      ST_CHK1: begin
        if (stat.t1_empty) begin
          cmd.wr1 = 1'b1;
          cmd.res = RES_PLACED;
        end else if (stat.kick_limit) begin
          cmd.res = RES_DROP_CUR;
        end else begin
          cmd.wr1   = 1'b1;
          cmd.swap1 = 1'b1;
          cmd.kick  = 1'b1;
        end
      end
      ST_H2A_GO: begin
        cmd.hash_go  = 1'b1;
        cmd.hash_src = HSRC_EVICT;
      end
      ST_H2A_WAIT: begin
        cmd.take_quot = stat.hash_done;
      end
      ST_H2B_GO: begin
        cmd.hash_go  = 1'b1;
        cmd.hash_src = HSRC_QUOT;
      end
      ST_H2B_WAIT: begin
        cmd.take_slot = stat.hash_done;
      end
      ST_CHK2: begin
        if (stat.t2_empty) begin
          cmd.wr2 = 1'b1;
          cmd.res = RES_PLACED;
        end else if (stat.kick_limit) begin
          cmd.res = RES_DROP_EVICT;
        end else begin
          cmd.wr2   = 1'b1;
          cmd.swap2 = 1'b1;
          cmd.kick  = 1'b1;
        end
      end
      ST_RD_OUT: begin
        cmd.res = RES_READ;
      end
      default: begin
        cmd.hash_src = HSRC_CUR;
      end
    endcase
  end

  // The divider only answers while the controller is waiting for it.
  a_hash_expected: assert property (@(posedge clk) disable iff (rst)
    stat.hash_done |->
      state == ST_H1_WAIT || state == ST_H2A_WAIT || state == ST_H2B_WAIT)
    else $error("divider result arrived outside a wait state");

  // An accepted request either starts work or is answered at once.
  a_accept_acts: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && start |-> cmd.load || cmd.res == RES_EMPTY)
    else $error("accepted request produced no action");

  a_one_table_write: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !cmd.wr1 && !cmd.wr2 && state == ST_CLEAR)
    else $error("table write during clearing pass");

endmodule
